// ===== rtl/abkf_pkg.sv =====
// abkf_pkg: shared types, opcodes and constants of the angle/bias Kalman filter.
// No dependencies.
package abkf_pkg;
   localparam int FRAC_SHIFT = 24;
   localparam int CFG_IDX_WIDTH = 2;

   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [1:0] CSR_START_ANGLE   = 2'd3;

   localparam logic [31:0] ANGLE_NOISE_RST   = 32'd16777;
   localparam logic [31:0] BIAS_NOISE_RST    = 32'd50332;
   localparam logic [31:0] MEASURE_NOISE_RST = 32'd503316;

   // Shared unit operations
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;
endpackage

// ===== rtl/angle_bias_kalman_filter_core.sv =====
// angle_bias_kalman_filter_core: top level, sequencer and state of the filter.
// Depends on abkf_pkg and abkf_mul_div.
//
// Usage:
//   req_ channel takes one IMU sample (meas_angle, meas_rate, time_step) when
//   req_valid is high and req_stall is low. req_stall stays high while a
//   sample is processed, until its result is loaded into the output register.
//   rsp_ channel presents filtered_angle and unbiased_rate; rsp_valid holds
//   with a steady payload while rsp_stall is high.
//   csr_ port writes the tuning noises and the start angle (index 3 also
//   loads the angle estimate); writes are taken only when idle.
// Sequence (DATA_WIDTH up to 32, unit operands carried at 36 bits):
//   10 multiplies and 2 divides per sample run through one shared unit.
//   A multiply runs as issue, 5 digit steps, done; a divide as issue, 60
//   quotient bits, done; between them run the add steps RATE, INNER and INNOV,
//   and S_OUT loads the result. A new sample is taken only once the last
//   result is loaded. A zero divisor skips both divides. A result still
//   stalled holds the next one, and with it the input, until it is taken.
// Reset: synchronous, active high. Noise registers return to defaults, angle,
//   bias, rate and covariance to zero, both channels go idle.
module angle_bias_kalman_filter_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_meas_angle,
   input  logic signed [31:0] req_meas_rate,
   input  logic [23:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_filtered_angle,
   output logic signed [31:0] rsp_unbiased_rate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int W = DATA_WIDTH;
   // wide enough for unsaturated sums with the 32-bit noise registers
   localparam int SW = ((W > 32) ? W : 32) + 4;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RATE = 5'd1;
   localparam logic [4:0] S_M_ANG = 5'd2;
   localparam logic [4:0] S_M_DTP = 5'd3;
   localparam logic [4:0] S_INNER = 5'd4;
   localparam logic [4:0] S_M_P00 = 5'd5;
   localparam logic [4:0] S_M_P11 = 5'd6;
   localparam logic [4:0] S_DIV0 = 5'd7;
   localparam logic [4:0] S_DIV1 = 5'd8;
   localparam logic [4:0] S_INNOV = 5'd9;
   localparam logic [4:0] S_M_K0Y = 5'd10;
   localparam logic [4:0] S_M_K1Y = 5'd11;
   localparam logic [4:0] S_M_C0 = 5'd12;
   localparam logic [4:0] S_M_C1 = 5'd13;
   localparam logic [4:0] S_M_C2 = 5'd14;
   localparam logic [4:0] S_M_C3 = 5'd15;
   localparam logic [4:0] S_OUT = 5'd16;

   logic [4:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic [31:0] an_ff, an_in, bn_ff, bn_in, mn_ff, mn_in;
   logic signed [W-1:0] ang_ff, ang_in, bias_ff, bias_in, rate_ff, rate_in;
   logic signed [W-1:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [W-1:0] z_ff, z_in, w_ff, w_in, t_ff, t_in;
   logic signed [SW-1:0] dt_ff, dt_in;
   logic signed [W-1:0] k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic signed [SW-1:0] s_ff, s_in;
   logic [31:0] oa_ff, oa_in, or_ff, or_in;
   logic rv_ff, rv_in;

   abkf_pkg::unit_ctl_type uctl;
   abkf_pkg::unit_sts_type usts;
   logic signed [SW-1:0] ua, ub;
   logic signed [W-1:0] ures;

   abkf_mul_div #(.W(W), .OW(SW)) u_unit (
      .clock(clock), .reset(reset), .ctl(uctl), .op_a(ua), .op_b(ub),
      .sts(usts), .result(ures)
   );

   function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
      if (v > SW'(MAXV)) return MAXV;
      else if (v < SW'(MINV)) return MINV;
      else return v[W-1:0];
   endfunction

   function automatic logic signed [SW-1:0] ext(input logic signed [W-1:0] v);
      return {{(SW-W){v[W-1]}}, v};
   endfunction

   function automatic logic signed [SW-1:0] noise(input logic [31:0] v);
      return $signed(SW'(v));
   endfunction

   function automatic logic signed [W-1:0] in_sat(input logic signed [31:0] v);
      logic signed [63:0] x;
      x = {{32{v[31]}}, v};
      if (x > 64'(MAXV)) return MAXV;
      else if (x < 64'(MINV)) return MINV;
      else return x[W-1:0];
   endfunction

   function automatic logic [31:0] out_sat(input logic signed [W-1:0] v);
      logic signed [63:0] x;
      x = 64'(v);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      else if (x < -64'sd2147483648) return 32'h80000000;
      else return x[31:0];
   endfunction

   logic unit_ok;
   assign unit_ok = issued_ff && usts.done;

   always_comb begin
      state_in = state_ff; issued_in = issued_ff;
      an_in = an_ff; bn_in = bn_ff; mn_in = mn_ff;
      ang_in = ang_ff; bias_in = bias_ff; rate_in = rate_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      z_in = z_ff; w_in = w_ff; dt_in = dt_ff; t_in = t_ff;
      k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff; s_in = s_ff;
      oa_in = oa_ff; or_in = or_ff; rv_in = rv_ff;
      uctl.start = 1'b0; uctl.op = abkf_pkg::OP_MUL;
      ua = dt_ff; ub = ext(rate_ff);

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            abkf_pkg::CSR_ANGLE_NOISE:   an_in = csr_data;
            abkf_pkg::CSR_BIAS_NOISE:    bn_in = csr_data;
            abkf_pkg::CSR_MEASURE_NOISE: mn_in = csr_data;
            abkf_pkg::CSR_START_ANGLE:   ang_in = in_sat(csr_data);
            default: ;
         endcase
      end

      // each multiply/divide state (S_DIV0 only with a nonzero divisor): issue once, then consume result on done
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               z_in = in_sat(req_meas_angle);
               w_in = in_sat(req_meas_rate);
               dt_in = SW'({1'b0, req_time_step});
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            rate_in = sat(ext(w_ff) - ext(bias_ff));
            state_in = S_M_ANG;
         end
         S_M_ANG: begin
            ua = dt_ff; ub = ext(rate_ff);
            if (unit_ok) begin
               ang_in = sat(ext(ang_ff) + ext(ures));
               state_in = S_M_DTP;
            end
         end
         S_M_DTP: begin
            ua = dt_ff; ub = ext(p11_ff);
            if (unit_ok) begin
               t_in = ures;
               state_in = S_INNER;
            end
         end
         S_INNER: begin
            t_in = sat(ext(t_ff) - ext(p01_ff) - ext(p10_ff) + noise(an_ff));
            // dtp11 still needed: keep it in k1 temporarily
            k1_in = t_ff;
            state_in = S_M_P00;
         end
         S_M_P00: begin
            ua = dt_ff; ub = ext(t_ff);
            if (unit_ok) begin
               p00_in = sat(ext(p00_ff) + ext(ures));
               p01_in = sat(ext(p01_ff) - ext(k1_ff));
               p10_in = sat(ext(p10_ff) - ext(k1_ff));
               state_in = S_M_P11;
            end
         end
         S_M_P11: begin
            ua = noise(bn_ff); ub = dt_ff;
            if (unit_ok) begin
               p11_in = sat(ext(p11_ff) + ext(ures));
               s_in = ext(p00_ff) + noise(mn_ff);
               state_in = S_DIV0;
            end
         end
         S_DIV0: begin
            uctl.op = abkf_pkg::OP_DIV;
            ua = ext(p00_ff); ub = s_ff;
            if (s_ff == '0) begin
               k0_in = '0; k1_in = '0;
               state_in = S_INNOV;
            end else if (unit_ok) begin
               k0_in = ures;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            uctl.op = abkf_pkg::OP_DIV;
            ua = ext(p10_ff); ub = s_ff;
            if (unit_ok) begin
               k1_in = ures;
               state_in = S_INNOV;
            end
         end
         S_INNOV: begin
            y_in = sat(ext(z_ff) - ext(ang_ff));
            state_in = S_M_K0Y;
         end
         S_M_K0Y: begin
            ua = ext(k0_ff); ub = ext(y_ff);
            if (unit_ok) begin
               ang_in = sat(ext(ang_ff) + ext(ures));
               state_in = S_M_K1Y;
            end
         end
         S_M_K1Y: begin
            ua = ext(k1_ff); ub = ext(y_ff);
            if (unit_ok) begin
               bias_in = sat(ext(bias_ff) + ext(ures));
               t_in = p00_ff;
               y_in = p01_ff;
               state_in = S_M_C0;
            end
         end
         S_M_C0: begin
            ua = ext(k0_ff); ub = ext(t_ff);
            if (unit_ok) begin
               p00_in = sat(ext(p00_ff) - ext(ures));
               state_in = S_M_C1;
            end
         end
         S_M_C1: begin
            ua = ext(k0_ff); ub = ext(y_ff);
            if (unit_ok) begin
               p01_in = sat(ext(p01_ff) - ext(ures));
               state_in = S_M_C2;
            end
         end
         S_M_C2: begin
            ua = ext(k1_ff); ub = ext(t_ff);
            if (unit_ok) begin
               p10_in = sat(ext(p10_ff) - ext(ures));
               state_in = S_M_C3;
            end
         end
         S_M_C3: begin
            ua = ext(k1_ff); ub = ext(y_ff);
            if (unit_ok) begin
               p11_in = sat(ext(p11_ff) - ext(ures));
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               oa_in = out_sat(ang_ff);
               or_in = out_sat(rate_ff);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // issue control for unit states
      if ((state_ff == S_M_ANG || state_ff == S_M_DTP || state_ff == S_M_P00 ||
           state_ff == S_M_P11 || state_ff == S_DIV1 || state_ff == S_M_K0Y ||
           state_ff == S_M_K1Y || state_ff == S_M_C0 || state_ff == S_M_C1 ||
           state_ff == S_M_C2 || state_ff == S_M_C3 ||
           (state_ff == S_DIV0 && s_ff != '0))) begin
         if (!issued_ff && !usts.busy) begin
            uctl.start = 1'b1;
            issued_in = 1'b1;
         end else if (unit_ok) begin
            issued_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issued_ff <= 1'b0;
         rv_ff <= 1'b0;
         an_ff <= abkf_pkg::ANGLE_NOISE_RST;
         bn_ff <= abkf_pkg::BIAS_NOISE_RST;
         mn_ff <= abkf_pkg::MEASURE_NOISE_RST;
         ang_ff <= '0; bias_ff <= '0; rate_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         rv_ff <= rv_in;
         an_ff <= an_in; bn_ff <= bn_in; mn_ff <= mn_in;
         ang_ff <= ang_in; bias_ff <= bias_in; rate_ff <= rate_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      end
      z_ff <= z_in; w_ff <= w_in; dt_ff <= dt_in; t_ff <= t_in;
      k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in; s_ff <= s_in;
      oa_ff <= oa_in; or_ff <= or_in;
   end

   assign req_stall = (state_ff != S_IDLE) || reset;
   assign csr_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rv_ff;
   assign rsp_filtered_angle = oa_ff;
   assign rsp_unbiased_rate = or_ff;

`ifndef SYNTH
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("sample accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered_angle)))
      else $error("stalled result changed");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      uctl.start |-> !usts.busy)
      else $error("unit started while busy");
`endif
endmodule

// ===== rtl/abkf_mul_div.sv =====
// abkf_mul_div: shared signed Q24 multiply / divide unit with saturation.
// Multiply: one radix-2^8 partial product per cycle. Divide: restoring,
// one quotient bit per cycle. Depends on abkf_pkg.
module abkf_mul_div #(
   parameter int W = 32,
   parameter int OW = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  abkf_pkg::unit_ctl_type ctl,
   input  logic signed [OW-1:0]  op_a,
   input  logic signed [OW-1:0]  op_b,
   output abkf_pkg::unit_sts_type sts,
   output logic signed [W-1:0]   result
);
   localparam int MW = OW;                    // magnitude width of an operand
   localparam int DIG = (MW + 7) / 8;         // 8-bit digits of multiplier
   localparam int DW = 8 * DIG;
   localparam int PW = 2 * MW;                // full product width
   localparam int DSTEPS = MW + abkf_pkg::FRAC_SHIFT; // quotient bits
   localparam int CW = $clog2(DSTEPS + 1);
   localparam int QW = DSTEPS;

   logic [MW-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [DW-1:0] mbx;
   logic [PW+8*DIG-1:0] acc_ff, acc_in;       // product accumulator / remainder
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in, div_ff, div_in;
   logic signed [W-1:0] res_ff, res_in;

   logic [MW+1:0] rem_sh, rem_sub;
   logic [MW-1:0] rem_cur;
   logic [7:0] digit;
   logic [PW+8*DIG-1:0] pprod;
   logic [PW+8*DIG-1:0] shifted;
   logic [QW-1:0] mag_v;
   logic over_v;
   logic [MW-1:0] hi_lim;

   assign mbx = DW'(mb_ff);
   assign digit = mbx[8*cnt_ff[$clog2(DIG)-1:0] +: 8];
   assign pprod = ({{(8*DIG+PW-MW){1'b0}}, ma_ff} * {{(PW+8*DIG-8){1'b0}}, digit})
                  << (8*cnt_ff[$clog2(DIG)-1:0]);
   assign rem_cur = acc_ff[MW-1:0];
   assign rem_sh = {1'b0, rem_cur, (cnt_ff < CW'(MW)) ? ma_ff[MW-1-cnt_ff] : 1'b0};
   assign rem_sub = rem_sh - {2'b00, mb_ff};
   assign shifted = acc_ff >> abkf_pkg::FRAC_SHIFT;
   assign hi_lim = MW'({(W-1){1'b1}});

   always_comb begin
      logic [MW-1:0] lim;
      lim = hi_lim + {{(MW-1){1'b0}}, neg_ff};
      if (div_ff) begin
         mag_v  = q_ff;
      end else begin
         mag_v  = shifted[QW-1:0];
      end
      over_v = (mag_v > {{(QW-MW){1'b0}}, lim});
      if (over_v) begin
         res_in = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         res_in = neg_ff ? W'(-mag_v) : W'(mag_v);
      end
   end

   always_comb begin
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      neg_in = neg_ff; div_in = div_ff;
      if (ctl.start && !busy_ff) begin
         ma_in = op_a[OW-1] ? MW'(-{op_a[OW-1], op_a}) : MW'({1'b0, op_a});
         mb_in = op_b[OW-1] ? MW'(-{op_b[OW-1], op_b}) : MW'({1'b0, op_b});
         neg_in = op_a[OW-1] ^ op_b[OW-1];
         div_in = (ctl.op == abkf_pkg::OP_DIV);
         acc_in = '0; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!rem_sub[MW+1]) begin
               acc_in = {{(PW+8*DIG-MW){1'b0}}, rem_sub[MW-1:0]};
               q_in = {q_ff[QW-2:0], 1'b1};
            end else begin
               acc_in = {{(PW+8*DIG-MW){1'b0}}, rem_sh[MW-1:0]};
               q_in = {q_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DSTEPS - 1)) begin
               busy_in = 1'b0; done_in = 1'b1;
            end
         end else begin
            acc_in = acc_ff + pprod;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIG - 1)) begin
               busy_in = 1'b0; done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
   end

   // result is taken from the final accumulator while done is high, then held in res_ff
   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) fin_ff <= 1'b0;
      else fin_ff <= done_in;
      if (fin_ff) res_ff <= res_in;
   end

   assign sts.busy = busy_ff || fin_ff;
   assign sts.done = done_ff && !fin_ff ? 1'b0 : done_ff;
   assign result = fin_ff ? res_in : res_ff;
endmodule
